FILE: design/dsth_pkg.sv
// dsth_pkg: shared types and constants for the room thermostat block
// no dependencies; imported by every module of the block

package dsth_pkg;

    // room table
    localparam int ROOMS   = 16;
    localparam int ROOM_AW = (ROOMS > 1) ? $clog2(ROOMS) : 1;

    // queue between front and back
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);

    // field widths
    localparam int ROOM_W  = 4;
    localparam int TEMP_W  = 16;
    localparam int SP_W    = 12;
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 10;
    localparam int SECS_W  = 16;

    // stream packing
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 40;

    // decode constants
    localparam logic [7:0]        FAMILY_DS18S20   = 8'h10;
    localparam logic [7:0]        CPD_REFINE       = 8'h10;
    localparam logic [TEMP_W-1:0] REFINE_MASK      = 16'hFFF0;
    localparam logic [TEMP_W-1:0] COUNT_BASE       = 16'd12;
    localparam logic [7:0]        RES_BITS_MASK    = 8'h60;

    // timing constants
    localparam logic [SECS_W-1:0]  SECS_PER_MINUTE  = 16'd60;
    localparam logic [DELAY_W-1:0] REOPEN_DELAY_RST = 10'd20;
    localparam logic [SECS_W-1:0]  REOPEN_SECS_RST  = 16'd1200;

    // configuration register indexes
    typedef enum logic [0:0] {
        CFG_HEATING_ENABLED = 1'b0,
        CFG_REOPEN_DELAY    = 1'b1
    } t_cfg_addr;

    // classified reading passed from front to back
    typedef struct packed {
        logic [ROOM_W-1:0] room;
        logic [TEMP_W-1:0] temperature;
        logic [SP_W-1:0]   setpoint;
        logic [TIME_W-1:0] now_seconds;
        logic              at_setpoint;  // setpoint <= temperature
    } t_item;

    // result carried to the output
    typedef struct packed {
        logic              valve_closed;
        logic [SP_W-1:0]   valve_demand;
        logic [TEMP_W-1:0] temperature;
        logic [ROOM_W-1:0] room_out;
    } t_result;

endpackage

FILE: design/dsth_front.sv
// dsth_front: unpacks the input transfer, decodes the scratchpad temperature
// and compares it with the setpoint; uses dsth_pkg

module dsth_front
    import dsth_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [IN_DATA_W-1:0] i_data,
    output logic                 o_push_valid,
    input  logic                 i_push_ready,
    output t_item                o_item
);

    logic [ROOM_W-1:0] w_room;
    logic [7:0]        w_family;
    logic [7:0]        w_lsb;
    logic [7:0]        w_msb;
    logic [7:0]        w_cfg;
    logic [7:0]        w_count_remain;
    logic [7:0]        w_count_per_deg;
    logic [TIME_W-1:0] w_now;
    logic [SP_W-1:0]   w_setpoint;
    logic [TEMP_W-1:0] w_raw;
    logic [TEMP_W-1:0] w_shifted;
    logic [TEMP_W-1:0] w_temp;
    logic              w_at_setpoint;

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    // field unpacking
    assign w_room          = i_data[3:0];
    assign w_family        = i_data[11:4];
    assign w_lsb           = i_data[19:12];
    assign w_msb           = i_data[27:20];
    assign w_cfg           = i_data[35:28];
    assign w_count_remain  = i_data[43:36];
    assign w_count_per_deg = i_data[51:44];
    assign w_now           = i_data[83:52];
    assign w_setpoint      = i_data[95:84];

    // temperature decode
    assign w_raw     = {w_msb, w_lsb};
    assign w_shifted = {w_raw[TEMP_W-4:0], 3'b000};

    always_comb begin
        w_temp = w_raw;
        if (w_family == FAMILY_DS18S20) begin
            if (w_count_per_deg == CPD_REFINE) begin
                w_temp = (w_shifted & REFINE_MASK) + COUNT_BASE
                         - {8'b0, w_count_remain};
            end else begin
                w_temp = w_shifted;
            end
        end else if ((w_cfg & RES_BITS_MASK) == 8'b0) begin
            w_temp = {w_raw[TEMP_W-1:3], 3'b000};
        end else begin
            w_temp = {w_raw[TEMP_W-1:2], 2'b00};
        end
    end

    // signed compare against the setpoint
    assign w_at_setpoint = $signed({{(TEMP_W-SP_W){w_setpoint[SP_W-1]}}, w_setpoint})
                           <= $signed(w_temp);

    always_comb begin
        n_item.room        = w_room;
        n_item.temperature = w_temp;
        n_item.setpoint    = w_setpoint;
        n_item.now_seconds = w_now;
        n_item.at_setpoint = w_at_setpoint;
    end

    // stage register, refilled when empty or draining into the queue
    assign o_ready      = !r_valid || i_push_ready;
    assign o_push_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end

endmodule

FILE: design/dsth_queue.sv
// dsth_queue: short first-in first-out queue of classified readings
// between front and back; uses dsth_pkg

module dsth_queue
    import dsth_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push_valid,
    output logic  o_push_ready,
    input  t_item i_item,
    output logic  o_pop_valid,
    input  logic  i_pop_ready,
    output t_item o_item
);

    t_item             r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_AW:0]     r_count;
    logic              w_push;
    logic              w_pop;

    assign o_push_ready = (r_count != (Q_AW+1)'(Q_DEPTH));
    assign o_pop_valid  = (r_count != '0);
    assign o_item       = r_mem[r_rd_ptr];

    assign w_push = i_push_valid && o_push_ready;
    assign w_pop  = o_pop_valid && i_pop_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: design/dsth_back.sv
// dsth_back: per-room valve state, configuration registers and the
// output register; uses dsth_pkg

module dsth_back
    import dsth_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  t_cfg_addr          i_cfg_addr,
    input  logic [DELAY_W-1:0] i_cfg_wdata,
    input  logic               i_pop_valid,
    output logic               o_pop_ready,
    input  t_item              i_item,
    output logic               o_valid,
    input  logic               i_ready,
    output t_result            o_result
);

    logic              r_heating;
    logic [SECS_W-1:0] r_delay_secs;

    logic              r_flag   [ROOMS];
    logic [TIME_W-1:0] r_since  [ROOMS];
    logic [SP_W-1:0]   r_demand [ROOMS];

    logic              r_out_valid;
    t_result           r_out;

    logic [ROOM_AW-1:0] w_idx;
    logic               w_in_range;
    logic               w_take;
    logic               w_flag;
    logic [TIME_W-1:0]  w_since;
    logic [SP_W-1:0]    w_demand;
    logic [TIME_W-1:0]  w_elapsed;
    logic               w_delay_over;
    logic               n_flag;
    logic [TIME_W-1:0]  n_since;
    logic [SP_W-1:0]    n_demand;
    t_result            n_out;

    // configuration writes; the delay is kept in seconds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heating    <= 1'b0;
            r_delay_secs <= REOPEN_SECS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_HEATING_ENABLED: r_heating <= i_cfg_wdata[0];
                CFG_REOPEN_DELAY:    r_delay_secs <= SECS_W'(
                                         SECS_W'(i_cfg_wdata) * SECS_PER_MINUTE);
                default: ;
            endcase
        end
    end

    // room lookup
    assign w_idx      = ROOM_AW'(i_item.room);
    assign w_in_range = (32'(i_item.room) < ROOMS);
    assign w_flag     = r_flag[w_idx];
    assign w_since    = r_since[w_idx];
    assign w_demand   = r_demand[w_idx];

    assign w_elapsed    = i_item.now_seconds - w_since;
    assign w_delay_over = (w_elapsed > TIME_W'(r_delay_secs));

    // valve update
    always_comb begin
        n_flag   = w_flag;
        n_since  = w_since;
        n_demand = w_demand;
        if (r_heating) begin
            if (i_item.at_setpoint && !w_flag) begin
                n_flag   = 1'b1;
                n_since  = i_item.now_seconds;
                n_demand = '0;
            end else if (!i_item.at_setpoint && w_delay_over) begin
                n_flag   = 1'b0;
                n_demand = i_item.setpoint;
            end
        end else begin
            n_demand = '0;
        end
    end

    always_comb begin
        n_out.room_out     = i_item.room;
        n_out.temperature  = i_item.temperature;
        n_out.valve_demand = w_in_range ? n_demand : '0;
        n_out.valve_closed = w_in_range ? n_flag : 1'b0;
    end

    // handshake with queue and output
    assign o_pop_ready = !r_out_valid || i_ready;
    assign w_take      = i_pop_valid && o_pop_ready;
    assign o_valid     = r_out_valid;
    assign o_result    = r_out;

    // room table, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ROOMS; i++) begin
                r_flag[i]   <= 1'b0;
                r_since[i]  <= '0;
                r_demand[i] <= '0;
            end
        end else if (w_take && w_in_range) begin
            r_flag[w_idx]   <= n_flag;
            r_since[w_idx]  <= n_since;
            r_demand[w_idx] <= n_demand;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop_ready) begin
            r_out_valid <= i_pop_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_out <= n_out;
        end
    end

endmodule

FILE: design/ds18x20_room_thermostat.sv
// ds18x20_room_thermostat: top level of the room thermostat block
// instantiates dsth_front, dsth_queue and dsth_back; uses dsth_pkg

// Each input transfer carries one room's DS18x20 scratchpad bytes, family code,
// setpoint and seconds clock; each produces exactly one output transfer with
// the decoded temperature in 1/16 degC and the room's valve demand and closed
// flag after the update. The block accepts one transfer per clock cycle while
// the output is not stalled, with the read-modify-write of the per-room valve
// table done in the back end as each reading is taken; a result passes through
// the front decode register, the queue and the output register. A four-entry
// queue between decode and valve update lets either side stall independently.
// Configuration: index 0 is heating enable (bit 0), index 1 the re-open delay
// in minutes (10 bits); write only while no reading is in flight.

module ds18x20_room_thermostat
    import dsth_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [0:0]            i_cfg_addr,
    input  logic [DELAY_W-1:0]    i_cfg_wdata,
    // readings in
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // sensor_index[3:0], family_code[11:4], scratch_lsb[19:12],
    // scratch_msb[27:20], scratch_config[35:28], count_remain[43:36],
    // count_per_degree[51:44], now_seconds[83:52], setpoint[95:84]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // results out
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // room_out[3:0], temperature[19:4], valve_demand[31:20],
    // valve_closed[32], zero fill [39:33]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic    w_push_valid;
    logic    w_push_ready;
    t_item   w_front_item;
    logic    w_pop_valid;
    logic    w_pop_ready;
    t_item   w_queue_item;
    t_result w_result;

    dsth_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_axis_tvalid),
        .o_ready      (o_s_axis_tready),
        .i_data       (i_s_axis_tdata),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_item       (w_front_item)
    );

    dsth_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_item       (w_front_item),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_item       (w_queue_item)
    );

    dsth_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (t_cfg_addr'(i_cfg_addr)),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pop_valid (w_pop_valid),
        .o_pop_ready (w_pop_ready),
        .i_item      (w_queue_item),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_result    (w_result)
    );

    // result packing with zero fill to whole bytes
    assign o_m_axis_tdata = {(OUT_DATA_W - $bits(t_result))'(0), w_result};

endmodule
